// File: rtl/core/fmos_pkg.sv
// ----------------------------------------------------------------------------
// fmos_pkg - shared constants, types and tables of the fm operator step unit
// Widths, algorithm word fields, the quarter-wave sine table and the
// reciprocal table used by the shared multiplier for the small divisions.
// ----------------------------------------------------------------------------
package fmos_pkg;

    // operator chain
    localparam int NUM_OPERATORS = 6;
    localparam int OP_W          = $clog2(NUM_OPERATORS);

    // algorithm words
    localparam int NUM_WORDS  = 6;
    localparam int WORD_IDX_W = $clog2(NUM_WORDS);
    localparam int WORD_W     = 9;

    localparam int W_FB_WRITE = 0;
    localparam int W_KEEP_MIX = 1;
    localparam int W_ADD      = 2;
    localparam int W_SRC_LO   = 3;
    localparam int W_COM_LO   = 6;

    typedef enum logic [2:0] {
        SRC_ZERO    = 3'd0,
        SRC_SAMPLE  = 3'd1,
        SRC_NEW_MIX = 3'd2,
        SRC_OLD_MIX = 3'd3,
        SRC_FB      = 3'd4,
        SRC_FB_AVG  = 3'd5
    } mod_src_t;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_FB_LEVEL = 3'd6;

    // sample formats
    localparam int SAMPLE_W = 16;
    localparam int MIX_W    = 19;
    localparam logic signed [MIX_W-1:0] MIX_MAX = 19'sd262143;
    localparam logic signed [MIX_W-1:0] MIX_MIN = -19'sd262144;

    // shared multiplier: signed a times unsigned b
    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = 21;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

    // 3.85 in q16
    localparam logic [MUL_B_W-1:0] MOD_DEPTH_Q16 = 21'd252314;

    // reciprocals ceil(2^20 / d) are exact for dividends below 2^17, d up to 8
    localparam int RECIP_SHIFT = 20;
    localparam int QUOT_W      = 17;
    localparam logic [2:0] COM_SIX = 3'd5;

    // sine table
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_HALF        = SINE_TABLE_DEPTH / 2;
    localparam int SINE_QTR         = SINE_TABLE_DEPTH / 4;
    localparam int SINE_QUARTER     = SINE_QTR + 1;
    localparam int SINE_U_STEP      = 65536 / SINE_TABLE_DEPTH;
    localparam int SINE_MAG_W       = 15;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    typedef logic [SINE_MAG_W-1:0] sine_rom_t [SINE_QUARTER];

    // configuration view handed to the sequencer
    typedef struct packed {
        logic [WORD_W-1:0]     rd_word;
        logic [CFG_DATA_W-1:0] fb_level;
    } cfg_view_t;

    // quarter-wave magnitudes from a taylor series in q30, built at elaboration
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t          rom;
        logic [63:0]        u;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        for (int j = 0; j < SINE_QUARTER; j++) begin
            u    = 64'(j) * 64'(SINE_U_STEP);
            x    = (u * PI_Q30) >> 15;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 5; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n & 1) == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = 0;
            r = (sum + 64'sd16384) >>> 15;
            if (r > 64'sd32767)
                r = 64'sd32767;
            rom[j] = SINE_MAG_W'(r);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // ceil(2^20 / (com + 1))
    function automatic logic [MUL_B_W-1:0] recip_q20(input logic [2:0] com);
        logic [MUL_B_W-1:0] m;
        case (com)
            3'd0:    m = 21'd1048576;
            3'd1:    m = 21'd524288;
            3'd2:    m = 21'd349526;
            3'd3:    m = 21'd262144;
            3'd4:    m = 21'd209716;
            3'd5:    m = 21'd174763;
            3'd6:    m = 21'd149797;
            3'd7:    m = 21'd131072;
            default: m = 21'd131072;
        endcase
        return m;
    endfunction

    // operator number modulo NUM_OPERATORS by repeated subtraction
    function automatic logic [OP_W-1:0] wrap_op(input logic [2:0] v);
        logic [3:0] t;
        t = {1'b0, v};
        for (int k = 0; k < 4; k++) begin
            if (t >= 4'(NUM_OPERATORS))
                t = t - 4'(NUM_OPERATORS);
        end
        return OP_W'(t);
    endfunction

    // operator number to algorithm word slot
    function automatic logic [WORD_IDX_W-1:0] word_slot(input logic [OP_W-1:0] op);
        logic [WORD_IDX_W:0] t;
        t = (WORD_IDX_W + 1)'(op);
        if (t >= (WORD_IDX_W + 1)'(NUM_WORDS))
            t = t - (WORD_IDX_W + 1)'(NUM_WORDS);
        return WORD_IDX_W'(t);
    endfunction

endpackage

// File: rtl/core/fm_operator_step_unit.sv
// ----------------------------------------------------------------------------
// fm_operator_step_unit - one fm operator evaluation per transfer
// Advances the operator phase, reads the sine at phase plus modulation,
// scales it and updates feedback, mix and modulation under the algorithm word.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  op_index, phase_step, level
//   out      output     out_valid / out_stall op_sample, mix_value, last
//   cfg      input      cfg_wr_en            cfg_index, cfg_data
//
// an item passes the angle, lookup, scale, round and divide steps, and also the
// feedback sum, round and divide steps when the modulation source is the feedback
// average; every multiplication goes through the one shared multiplier.
// reset clears phases, feedback pair, mix, modulation, output valid and state.
// a finished result waits in the output register; while it is stalled and a
// second result is ready, the sequencer holds and in_stall stays high.
// ----------------------------------------------------------------------------
module fm_operator_step_unit
    import fmos_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 op_index,
    input  logic [15:0]                phase_step,
    input  logic [15:0]                level,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] op_sample,
    output logic signed [MIX_W-1:0]    mix_value,
    output logic                       last,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_ANGLE  = 10'b0000000010,
        ST_LOOKUP = 10'b0000000100,
        ST_SCALE  = 10'b0000001000,
        ST_ROUND  = 10'b0000010000,
        ST_DIVIDE = 10'b0000100000,
        ST_FBSUM  = 10'b0001000000,
        ST_FBRND  = 10'b0010000000,
        ST_FBDIV  = 10'b0100000000,
        ST_FINISH = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // architectural state
    logic [15:0]              op_phase_reg [NUM_OPERATORS];
    logic signed [MIX_W-1:0]  mod_value_reg;
    logic signed [MIX_W-1:0]  mix_acc_reg;
    logic signed [SAMPLE_W-1:0] fb0_reg;
    logic signed [SAMPLE_W-1:0] fb1_reg;
    logic                     out_valid_reg;

    // per-item working registers
    logic [OP_W-1:0]          op_reg;
    logic [15:0]              level_reg;
    logic [15:0]              phase_cur_reg;
    logic [15:0]              angle_reg;
    logic [SINE_MAG_W-1:0]    sine_mag_reg;
    logic                     neg_reg;
    logic [2:0]               com_reg;
    logic [WORD_W-1:0]        word_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                     fb_neg_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic signed [MIX_W-1:0]  out_mix_reg;
    logic                     out_last_reg;

    logic                     accept;
    logic                     out_load;
    logic [OP_W-1:0]          op_in;
    logic [15:0]              phase_sum;
    logic [OP_W-1:0]          prev_op;
    logic [WORD_IDX_W-1:0]    rd_addr;
    cfg_view_t                cfg_view;

    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic signed [MUL_P_W-1:0] prod;

    logic [31:0]               off_sum;
    logic [15:0]               angle_next;
    logic [SINE_IDX_W-1:0]     sine_idx;
    logic [SINE_IDX_W-2:0]     sine_half;
    logic [SINE_IDX_W-2:0]     sine_fold;
    logic [32:0]               round_sum;
    logic [QUOT_W-1:0]         round_y;
    logic [QUOT_W-1:0]         quot;
    logic [SINE_MAG_W-1:0]     quot_sat;
    logic signed [SAMPLE_W-1:0] sample_c;
    logic signed [SAMPLE_W-1:0] fb0_new;
    logic signed [SAMPLE_W-1:0] fb1_new;
    logic signed [MIX_W:0]     mix_sum;
    logic signed [MIX_W-1:0]   new_mix;
    logic signed [SAMPLE_W:0]  fb_sum;
    logic [SAMPLE_W:0]         fb_mag;
    logic [32:0]               fb_rnd_sum;
    logic [QUOT_W-1:0]         fb_y;
    logic [QUOT_W-1:0]         fb_quot;
    mod_src_t                  src;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    assign op_in     = wrap_op(op_index);
    assign phase_sum = op_phase_reg[op_in] + phase_step;
    assign prev_op   = (op_reg == '0) ? OP_W'(NUM_OPERATORS - 1) : op_reg - 1'b1;
    assign rd_addr   = (state_reg == ST_ANGLE) ? word_slot(prev_op) : word_slot(op_reg);
    assign src       = mod_src_t'(word_reg[W_SRC_LO +: 3]);

    fmos_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rd_addr   (rd_addr),
        .view      (cfg_view)
    );

    fmos_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // modulation offset, floor((mod * 3.85q16 + half) / 65536)
    assign off_sum    = prod[31:0] + 32'd32768;
    assign angle_next = phase_cur_reg + off_sum[31:16];

    // quarter-wave fold of the table index
    assign sine_idx  = angle_reg[15 -: SINE_IDX_W];
    assign sine_half = sine_idx[SINE_IDX_W-2:0];
    assign sine_fold = (sine_half > (SINE_IDX_W - 1)'(SINE_QTR))
                     ? (SINE_IDX_W - 1)'(SINE_IDX_W'(SINE_HALF) - {1'b0, sine_half})
                     : sine_half;

    // rounding bias of half the divisor, then the reciprocal pass
    assign round_sum = {1'b0, prod[31:0]} + {14'b0, ({1'b0, com_reg} + 4'd1), 15'b0};
    assign round_y   = round_sum[32:16];

    assign quot     = prod[RECIP_SHIFT +: QUOT_W];
    assign quot_sat = (quot > QUOT_W'(32767)) ? 15'd32767 : quot[SINE_MAG_W-1:0];
    assign sample_c = neg_reg ? -$signed({1'b0, quot_sat}) : $signed({1'b0, quot_sat});

    assign fb0_new = word_reg[W_FB_WRITE] ? sample_c : fb0_reg;
    assign fb1_new = word_reg[W_FB_WRITE] ? fb0_reg : fb1_reg;

    assign mix_sum = (word_reg[W_KEEP_MIX] ? {mix_acc_reg[MIX_W-1], mix_acc_reg}
                                           : (MIX_W + 1)'(0))
                   + (word_reg[W_ADD] ? {{(MIX_W - SAMPLE_W + 1){sample_c[SAMPLE_W-1]}},
                                         sample_c}
                                      : (MIX_W + 1)'(0));
    assign new_mix = (mix_sum > $signed({MIX_MAX[MIX_W-1], MIX_MAX})) ? MIX_MAX
                   : (mix_sum < $signed({MIX_MIN[MIX_W-1], MIX_MIN})) ? MIX_MIN
                   : mix_sum[MIX_W-1:0];

    // feedback average, fb_level * (fb0 + fb1) / (6 * 65536)
    assign fb_sum     = {fb0_reg[SAMPLE_W-1], fb0_reg} + {fb1_reg[SAMPLE_W-1], fb1_reg};
    assign fb_mag     = fb_sum[SAMPLE_W] ? 17'(-fb_sum) : 17'(fb_sum);
    assign fb_rnd_sum = {1'b0, prod[31:0]} + 33'd196608;
    assign fb_y       = fb_rnd_sum[32:16];
    assign fb_quot    = prod[RECIP_SHIFT +: QUOT_W];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_IDLE:
            begin
                mul_a = {mod_value_reg[MIX_W-1], mod_value_reg};
                mul_b = MOD_DEPTH_Q16;
            end
            ST_SCALE:
            begin
                mul_a = {5'b0, sine_mag_reg};
                mul_b = {5'b0, level_reg};
            end
            ST_ROUND:
            begin
                mul_a = {3'b0, round_y};
                mul_b = recip_q20(com_reg);
            end
            ST_FBSUM:
            begin
                mul_a = {3'b0, fb_mag};
                mul_b = {5'b0, cfg_view.fb_level};
            end
            ST_FBRND:
            begin
                mul_a = {3'b0, fb_y};
                mul_b = recip_q20(COM_SIX);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_ANGLE;
            ST_ANGLE:  state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_DIVIDE;
            ST_DIVIDE: state_next = (src == SRC_FB_AVG) ? ST_FBSUM : ST_FINISH;
            ST_FBSUM:  state_next = ST_FBRND;
            ST_FBRND:  state_next = ST_FBDIV;
            ST_FBDIV:  state_next = ST_FINISH;
            ST_FINISH: if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int k = 0; k < NUM_OPERATORS; k++)
                op_phase_reg[k] <= '0;
            mod_value_reg <= '0;
            mix_acc_reg   <= '0;
            fb0_reg       <= '0;
            fb1_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                op_phase_reg[op_in] <= phase_sum;
            if (state_reg == ST_DIVIDE)
            begin
                fb0_reg     <= fb0_new;
                fb1_reg     <= fb1_new;
                mix_acc_reg <= new_mix;
                case (src)
                    SRC_ZERO:    mod_value_reg <= '0;
                    SRC_SAMPLE:  mod_value_reg <= MIX_W'(sample_c);
                    SRC_NEW_MIX: mod_value_reg <= new_mix;
                    SRC_OLD_MIX: mod_value_reg <= mix_acc_reg;
                    SRC_FB:      mod_value_reg <= MIX_W'(fb0_new);
                    default:     mod_value_reg <= mod_value_reg;
                endcase
            end
            if (state_reg == ST_FBDIV)
                mod_value_reg <= fb_neg_reg ? -$signed({2'b0, fb_quot})
                                            : $signed({2'b0, fb_quot});
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= op_in;
            level_reg     <= level;
            phase_cur_reg <= phase_sum;
        end
        if (state_reg == ST_ANGLE)
            angle_reg <= angle_next;
        if (state_reg == ST_LOOKUP)
        begin
            sine_mag_reg <= SINE_ROM[sine_fold];
            neg_reg      <= sine_idx[SINE_IDX_W-1];
            com_reg      <= cfg_view.rd_word[W_COM_LO +: 3];
        end
        if (state_reg == ST_SCALE)
            word_reg <= cfg_view.rd_word;
        if (state_reg == ST_DIVIDE)
            sample_reg <= sample_c;
        if (state_reg == ST_FBSUM)
            fb_neg_reg <= fb_sum[SAMPLE_W];
        if (out_load)
        begin
            out_sample_reg <= sample_reg;
            out_mix_reg    <= mix_acc_reg;
            out_last_reg   <= (op_reg == OP_W'(NUM_OPERATORS - 1));
        end
    end

    assign out_valid = out_valid_reg;
    assign op_sample = out_sample_reg;
    assign mix_value = out_mix_reg;
    assign last      = out_last_reg;

    a_accept_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while an item is in progress");

    a_mix_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> $stable(mix_acc_reg))
        else $error("mix accumulator moved outside the update step");

    a_mod_update_steps: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == ST_DIVIDE || state_reg == ST_FBDIV) |=> $stable(mod_value_reg))
        else $error("modulation value moved outside its update steps");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared without a finished item");

endmodule

// File: rtl/core/fmos_cfg.sv
// ----------------------------------------------------------------------------
// fmos_cfg - algorithm word and feedback level registers
// Write-only register file with one registered read port for the words.
// ----------------------------------------------------------------------------
module fmos_cfg
    import fmos_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [WORD_IDX_W-1:0] rd_addr,
    output cfg_view_t             view
);

    logic [WORD_W-1:0]     word_reg [NUM_WORDS];
    logic [CFG_DATA_W-1:0] fb_level_reg;
    logic [WORD_W-1:0]     rd_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_WORDS; k++)
                word_reg[k] <= '0;
            fb_level_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index < CFG_IDX_W'(NUM_WORDS))
                word_reg[WORD_IDX_W'(cfg_index)] <= cfg_data[WORD_W-1:0];
            else if (cfg_index == REG_FB_LEVEL)
                fb_level_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_word_reg <= word_reg[rd_addr];
    end

    assign view.rd_word  = rd_word_reg;
    assign view.fb_level = fb_level_reg;

endmodule

// File: rtl/core/fmos_mul.sv
// ----------------------------------------------------------------------------
// fmos_mul - shared multiplier
// Signed by unsigned product, registered; one result per clock.
// ----------------------------------------------------------------------------
module fmos_mul
    import fmos_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic        [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] prod
);

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * $signed({1'b0, b});
    end

    assign prod = prod_reg;

endmodule

// File: test/fm_operator_step_checker.sv
// ----------------------------------------------------------------------------
// fm_operator_step_checker - result predictor and comparator for the fm unit
// Follows register writes and input transfers, works out each operator
// step from its own copy of the phases, feedback pair, mix and modulation,
// and compares every output transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module fm_operator_step_checker
    import fmos_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [2:0]                 op_index,
    input  logic [15:0]                phase_step,
    input  logic [15:0]                level,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [SAMPLE_W-1:0] op_sample,
    input  logic signed [MIX_W-1:0]    mix_value,
    input  logic                       last,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output int                         fail_count,
    output int                         results_seen,
    output int                         waiting
);

    localparam longint MOD_DEPTH = 252314;
    localparam longint MIX_HI    = 262143;
    localparam longint MIX_LO    = -262144;
    localparam int     MAX_SHOWN = 10;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [MIX_W-1:0]    mix;
        logic                       is_last;
    } op_result_t;

    logic [WORD_W-1:0]          alg_word [NUM_WORDS];
    logic [15:0]                fb_depth;
    logic [15:0]                phase_acc [NUM_OPERATORS];
    logic signed [MIX_W-1:0]    mod_reg;
    logic signed [MIX_W-1:0]    mix_reg;
    logic signed [SAMPLE_W-1:0] fb_prev [2];

    op_result_t pending_results [$];
    int         mismatches;
    int         received;

    // division rounded half away from zero
    function automatic longint div_nearest(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // table sine at a 16-bit angle, magnitude from a q30 taylor series
    function automatic int sine_lookup(input logic [15:0] angle);
        logic [63:0] idx;
        logic [63:0] u;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      mag;
        logic        neg;
        idx = (64'(angle) * 64'(SINE_TABLE_DEPTH)) >> 16;
        u   = (idx * 64'd65536) / 64'(SINE_TABLE_DEPTH);
        neg = 1'b0;
        if (u >= 64'd32768)
        begin
            neg = 1'b1;
            u   = u - 64'd32768;
        end
        if (u > 64'd16384)
            u = 64'd32768 - u;
        x    = (u * PI_Q30) >> 15;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 5; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        mag = (sum + 16384) >>> 15;
        if (mag > 32767)
            mag = 32767;
        return neg ? -int'(mag) : int'(mag);
    endfunction

    // one operator step: updates the predictor state and returns the result
    function automatic op_result_t advance_operator(input logic [2:0]  op_in,
                                                    input logic [15:0] step,
                                                    input logic [15:0] lvl);
        op_result_t        res;
        int                op;
        int                prev;
        logic [WORD_W-1:0] pword;
        logic [WORD_W-1:0] word;
        logic [2:0]        com;
        logic [2:0]        src;
        longint            off;
        logic [15:0]       angle;
        int                sine;
        longint            smp;
        longint            acc;
        op    = int'(op_in) % NUM_OPERATORS;
        prev  = (op == 0) ? NUM_OPERATORS - 1 : op - 1;
        pword = alg_word[prev % NUM_WORDS];
        word  = alg_word[op % NUM_WORDS];
        com   = pword[W_COM_LO +: 3];
        src   = word[W_SRC_LO +: 3];

        phase_acc[op] = phase_acc[op] + step;
        off   = (longint'(mod_reg) * MOD_DEPTH + 32768) >>> 16;
        angle = phase_acc[op] + off[15:0];
        sine  = sine_lookup(angle);
        smp   = div_nearest(longint'(sine) * longint'(lvl),
                            longint'(65536) * (longint'(com) + 1));
        if (smp > 32767)
            smp = 32767;
        if (smp < -32768)
            smp = -32768;

        if (word[W_FB_WRITE])
        begin
            fb_prev[1] = fb_prev[0];
            fb_prev[0] = SAMPLE_W'(smp);
        end

        acc = 0;
        if (word[W_KEEP_MIX])
            acc = acc + longint'(mix_reg);
        if (word[W_ADD])
            acc = acc + smp;
        if (acc > MIX_HI)
            acc = MIX_HI;
        if (acc < MIX_LO)
            acc = MIX_LO;

        // old mix is still in mix_reg here
        case (src)
            SRC_ZERO:    mod_reg = '0;
            SRC_SAMPLE:  mod_reg = MIX_W'(smp);
            SRC_NEW_MIX: mod_reg = MIX_W'(acc);
            SRC_OLD_MIX: mod_reg = mix_reg;
            SRC_FB:      mod_reg = MIX_W'(fb_prev[0]);
            SRC_FB_AVG:  mod_reg = MIX_W'(div_nearest(longint'(fb_depth) *
                                       (longint'(fb_prev[0]) + longint'(fb_prev[1])),
                                       longint'(65536) * 6));
            default:     mod_reg = mod_reg;
        endcase
        mix_reg = MIX_W'(acc);

        res.sample  = SAMPLE_W'(smp);
        res.mix     = mix_reg;
        res.is_last = (op == NUM_OPERATORS - 1);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        op_result_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_WORDS; k++)
                alg_word[k] = '0;
            for (int k = 0; k < NUM_OPERATORS; k++)
                phase_acc[k] = '0;
            fb_depth   = '0;
            mod_reg    = '0;
            mix_reg    = '0;
            fb_prev[0] = '0;
            fb_prev[1] = '0;
            pending_results.delete();
            mismatches = 0;
            received   = 0;
            fail_count   <= 0;
            results_seen <= 0;
            waiting      <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index < NUM_WORDS)
                    alg_word[cfg_index] = cfg_data[WORD_W-1:0];
                else if (cfg_index == REG_FB_LEVEL)
                    fb_depth = cfg_data;
            end

            if (in_valid && !in_stall)
                pending_results.push_back(advance_operator(op_index, phase_step, level));

            if (out_valid && !out_stall)
            begin
                received++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result: op_sample %0d mix_value %0d last %0b",
                                 op_sample, mix_value, last);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (op_sample !== want.sample || mix_value !== want.mix ||
                        last !== want.is_last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                        begin
                            $write("result %0d mismatch: op_sample exp %0d got %0d, ",
                                   received, want.sample, op_sample);
                            $display("mix_value exp %0d got %0d, last exp %0b got %0b",
                                     want.mix, mix_value, want.is_last, last);
                        end
                    end
                end
            end

            fail_count   <= mismatches;
            results_seen <= received;
            waiting      <= pending_results.size();
        end
    end

endmodule

// File: test/fm_operator_step_unit_test.sv
// ----------------------------------------------------------------------------
// fm_operator_step_unit_test - top level test of the fm operator step unit
// Drives operator updates and register settings with random pacing on both
// channels; a checker beside the block predicts and compares every result.
// A directed opening covers field extremes, every modulation source and the
// operator wrap cases, then random frames run under several settings.
// ----------------------------------------------------------------------------
module fm_operator_step_unit_test;
    import fmos_pkg::*;

    localparam int               CYCLE_LIMIT    = 500000;
    localparam int               SETTLE_CYCLES  = 12;
    localparam int               PHASE_ITEMS    = 150;
    localparam int               NUM_PHASES     = 6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    // source codes that leave the modulation value alone
    localparam logic [2:0]       SRC_HOLD_LO    = 3'd6;
    localparam logic [2:0]       SRC_HOLD_HI    = 3'd7;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [2:0]                 op_index;
    logic [15:0]                phase_step;
    logic [15:0]                level;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] op_sample;
    logic signed [MIX_W-1:0]    mix_value;
    logic                       last;
    logic                       cfg_wr_en;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    int fail_count;
    int results_seen;
    int waiting;

    int items_sent     = 0;
    int settings_done  = 0;
    int cycle_count    = 0;
    int stall_left     = 0;
    int stall_pick;
    int burst_left     = 0;

    logic [WORD_W-1:0]     word_plan [NUM_WORDS];
    logic [CFG_DATA_W-1:0] depth_plan;

    fm_operator_step_unit dut (.*);

    fm_operator_step_checker check_u (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d results in",
                     cycle_count, results_seen, items_sent);
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver back-pressure: stalled and free stretches, some long free runs
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 40)
            begin
                out_stall  <= 1'b1;
                stall_left <= idle_span();
            end
            else if (stall_pick < 95)
            begin
                out_stall  <= 1'b0;
                stall_left <= idle_span();
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(100, 300);
            end
        end
    end

    function automatic logic [WORD_W-1:0] pack_word(input logic [2:0] com,
                                                    input logic [2:0] src,
                                                    input logic       keep,
                                                    input logic       add,
                                                    input logic       fb_write);
        logic [WORD_W-1:0] w;
        w = '0;
        w[W_COM_LO +: 3] = com;
        w[W_SRC_LO +: 3] = src;
        w[W_KEEP_MIX]    = keep;
        w[W_ADD]         = add;
        w[W_FB_WRITE]    = fb_write;
        return w;
    endfunction

    function automatic logic [15:0] rand_step(input logic mostly_still);
        int r;
        r = $urandom_range(0, 99);
        if (mostly_still && r < 80)
            return 16'd0;
        if (r < 5)
            return 16'd0;
        if (r < 10)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'hFFFF;
        if (r < 13)
            return 16'd0;
        return 16'($urandom);
    endfunction

    // holds the payload until the transfer happens; valid stays high after
    task automatic push_item(input logic [2:0] op, input logic [15:0] step,
                             input logic [15:0] lvl);
        in_valid   <= 1'b1;
        op_index   <= op;
        phase_step <= step;
        level      <= lvl;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic pace_sender();
        int n;
        if (burst_left > 0)
        begin
            burst_left--;
            n = 0;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            burst_left = $urandom_range(20, 60);
            n = 0;
        end
        else
            n = idle_span();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // all words, the feedback depth, and a write to the unused index
    task automatic write_plan();
        for (int k = 0; k < NUM_WORDS; k++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(k);
            cfg_data  <= {7'($urandom), word_plan[k]};
            @(posedge clk);
        end
        cfg_index <= REG_FB_LEVEL;
        cfg_data  <= depth_plan;
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= 16'($urandom);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_done++;
    endtask

    task automatic send_frame(input logic [15:0] step, input logic [15:0] lvl);
        for (int k = 0; k < NUM_OPERATORS; k++)
        begin
            push_item(3'(k), step, lvl);
            pace_sender();
        end
    endtask

    initial
    begin
        int shape;
        int first;
        int span;
        int sent_in_phase;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op_index   = '0;
        phase_step = '0;
        level      = '0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // settings as after reset, field extremes and out-of-range operators
        push_item(3'd0, 16'd0, 16'd0);
        pace_sender();
        push_item(3'd5, 16'hFFFF, 16'hFFFF);
        pace_sender();
        push_item(3'd6, 16'd16384, 16'hFFFF);
        pace_sender();
        push_item(3'd7, 16'd32768, 16'hFFFF);
        wait_for_results();

        // every modulation source, large com values, full feedback depth
        word_plan[0] = pack_word(3'd0, SRC_SAMPLE,  1'b0, 1'b1, 1'b1);
        word_plan[1] = pack_word(3'd1, SRC_NEW_MIX, 1'b1, 1'b1, 1'b0);
        word_plan[2] = pack_word(3'd2, SRC_OLD_MIX, 1'b1, 1'b1, 1'b1);
        word_plan[3] = pack_word(3'd3, SRC_FB,      1'b1, 1'b1, 1'b1);
        word_plan[4] = pack_word(3'd6, SRC_FB_AVG,  1'b1, 1'b1, 1'b1);
        word_plan[5] = pack_word(3'd7, SRC_ZERO,    1'b1, 1'b1, 1'b0);
        depth_plan   = 16'hFFFF;
        write_plan();
        send_frame(16'd4099, 16'hFFFF);
        send_frame(16'd4099, 16'hFFFF);
        push_item(3'd6, 16'd1000, 16'hFFFF);
        pace_sender();
        push_item(3'd7, 16'd1000, 16'hFFFF);
        wait_for_results();

        // sources that hold the modulation value, beside feedback average and sample
        word_plan[0] = pack_word(3'd5, SRC_HOLD_LO, 1'b1, 1'b1, 1'b1);
        word_plan[1] = pack_word(3'd4, SRC_HOLD_HI, 1'b1, 1'b0, 1'b1);
        word_plan[2] = pack_word(3'd0, SRC_FB_AVG,  1'b0, 1'b1, 1'b1);
        word_plan[3] = pack_word(3'd7, SRC_SAMPLE,  1'b1, 1'b1, 1'b0);
        word_plan[4] = pack_word(3'd6, SRC_HOLD_LO, 1'b1, 1'b1, 1'b1);
        word_plan[5] = pack_word(3'd0, SRC_HOLD_HI, 1'b0, 1'b1, 1'b1);
        depth_plan   = 16'd32768;
        write_plan();
        push_item(3'd0, 16'd1, 16'd0);
        pace_sender();
        push_item(3'd1, 16'h8000, 16'd1);
        pace_sender();
        push_item(3'd2, 16'h7FFF, 16'd32768);
        pace_sender();
        push_item(3'd3, 16'hAAAA, 16'hFFFF);
        pace_sender();
        push_item(3'd4, 16'h5555, 16'h8001);
        pace_sender();
        push_item(3'd5, 16'd12345, 16'hFFFF);
        wait_for_results();

        // random frames under a run of settings, extremes first
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    for (int k = 0; k < NUM_WORDS; k++)
                        word_plan[k] = '1;
                    depth_plan = 16'hFFFF;
                end
                1:
                begin
                    for (int k = 0; k < NUM_WORDS; k++)
                        word_plan[k] = '0;
                    depth_plan = 16'd0;
                end
                2:
                begin
                    // accumulate at a steady phase to drive the mix into saturation
                    for (int k = 0; k < NUM_WORDS; k++)
                        word_plan[k] = pack_word(3'd0, SRC_HOLD_LO, 1'b1, 1'b1, 1'b1);
                    depth_plan = 16'($urandom);
                end
                default:
                begin
                    for (int k = 0; k < NUM_WORDS; k++)
                        word_plan[k] = WORD_W'($urandom);
                    depth_plan = rand_level();
                end
            endcase
            write_plan();

            sent_in_phase = 0;
            while (sent_in_phase < PHASE_ITEMS)
            begin
                shape = $urandom_range(0, 99);
                if (shape < 75)
                begin
                    first = 0;
                    span  = NUM_OPERATORS;
                end
                else if (shape < 90)
                begin
                    first = $urandom_range(0, 7);
                    span  = 1;
                end
                else
                begin
                    // broken frame
                    first = $urandom_range(0, NUM_OPERATORS - 1);
                    span  = $urandom_range(1, NUM_OPERATORS - 1);
                end
                for (int j = 0; j < span; j++)
                begin
                    push_item(3'(first + j), rand_step(p == 2), rand_level());
                    sent_in_phase++;
                    if ($urandom_range(0, 149) == 0)
                        wait_for_results();
                    else
                        pace_sender();
                end
            end
            wait_for_results();
        end

        repeat (20) @(posedge clk);
        $display("ran %0d operator steps under %0d register settings, %0d results checked",
                 items_sent, settings_done, results_seen);
        $display("covered all modulation sources, com 0 to 7 and operator indexes 0 to 7");
        if (fail_count == 0 && waiting == 0 && results_seen == items_sent)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
